/* rtl/dll_pkg.sv */
`timescale 1ns / 1ps

package dll_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam idx_t NULL_IDX = IDX_W'(CAPACITY);

  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_REMOVE     = 3'd2;
  localparam logic [2:0] REQ_LIST_FWD   = 3'd3;
  localparam logic [2:0] REQ_LIST_BWD   = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic  en;
    addr_t addr;
  } rd_req_t;

  typedef struct packed {
    logic               val_en;
    logic               next_en;
    logic               prev_en;
    addr_t              addr;
    logic signed [31:0] value;
    idx_t               next;
    idx_t               prev;
  } wr_req_t;

  typedef struct packed {
    logic signed [31:0] value;
    idx_t               next;
    idx_t               prev;
  } entry_t;

  typedef struct packed {
    logic               valid;
    logic [1:0]         status;
    logic signed [31:0] value;
    logic               last;
  } rsp_t;

  function automatic logic idx_valid(idx_t i);
    return i < NULL_IDX;
  endfunction

endpackage

/* rtl/dll_req_if.sv */
`timescale 1ns / 1ps

interface dll_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [31:0] value;

  modport source (output valid, req_type, value, input ready);
  modport sink (input valid, req_type, value, output ready);
endinterface

/* rtl/dll_rsp_if.sv */
`timescale 1ns / 1ps

interface dll_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] value_out;
  logic               last;

  modport source (output valid, status, value_out, last, input ready);
  modport sink (input valid, status, value_out, last, output ready);
endinterface

/* rtl/dll_store.sv */
`timescale 1ns / 1ps

module dll_store (
  input  logic             clk,
  input  dll_pkg::rd_req_t rd_req,
  input  dll_pkg::wr_req_t wr_req,
  output dll_pkg::entry_t  rd_data
);

  logic signed [31:0] val_mem  [dll_pkg::CAPACITY];
  dll_pkg::idx_t      next_mem [dll_pkg::CAPACITY];
  dll_pkg::idx_t      prev_mem [dll_pkg::CAPACITY];
  dll_pkg::entry_t    rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_req.val_en) begin
      val_mem[wr_req.addr] <= wr_req.value;
    end
    if (wr_req.next_en) begin
      next_mem[wr_req.addr] <= wr_req.next;
    end
    if (wr_req.prev_en) begin
      prev_mem[wr_req.addr] <= wr_req.prev;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      rd_data_r.value <= val_mem[rd_req.addr];
      rd_data_r.next  <= next_mem[rd_req.addr];
      rd_data_r.prev  <= prev_mem[rd_req.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/dll_ctrl.sv */
`timescale 1ns / 1ps

module dll_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_req_type,
  input  logic signed [31:0] in_value,
  output dll_pkg::rsp_t      emit,
  input  logic               emit_ok,
  output dll_pkg::rd_req_t   rd_req,
  output dll_pkg::wr_req_t   wr_req,
  input  dll_pkg::entry_t    rd_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_ALLOC, S_LINK, S_SEARCH,
    S_UNLINK_PREV, S_UNLINK_NEXT, S_LIST, S_RESULT
  } state_t;

  state_t             state_r, state_nxt;
  logic [2:0]         type_r, type_nxt;
  logic signed [31:0] value_r, value_nxt;
  logic [1:0]         status_r, status_nxt;
  dll_pkg::idx_t      head_r, head_nxt;
  dll_pkg::idx_t      tail_r, tail_nxt;
  dll_pkg::idx_t      count_r, count_nxt;
  logic [dll_pkg::CAPACITY-1:0] free_r, free_nxt;
  dll_pkg::addr_t     scan_r, scan_nxt;
  dll_pkg::addr_t     step_r, step_nxt;
  dll_pkg::idx_t      cur_r, cur_nxt;
  dll_pkg::idx_t      new_r, new_nxt;
  dll_pkg::idx_t      unl_prev_r, unl_prev_nxt;
  dll_pkg::idx_t      unl_next_r, unl_next_nxt;

  dll_pkg::idx_t      list_nx;
  dll_pkg::idx_t      start_idx;
  logic               list_last;
  logic               step_max;

  assign step_max  = (step_r == dll_pkg::ADDR_W'(dll_pkg::CAPACITY - 1));
  assign list_nx   = (type_r == dll_pkg::REQ_LIST_FWD) ? rd_data.next : rd_data.prev;
  assign list_last = !dll_pkg::idx_valid(list_nx) || step_max;
  assign start_idx = (type_r == dll_pkg::REQ_LIST_FWD) ? head_r : tail_r;
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    type_nxt     = type_r;
    value_nxt    = value_r;
    status_nxt   = status_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    free_nxt     = free_r;
    scan_nxt     = scan_r;
    step_nxt     = step_r;
    cur_nxt      = cur_r;
    new_nxt      = new_r;
    unl_prev_nxt = unl_prev_r;
    unl_next_nxt = unl_next_r;
    rd_req       = '0;
    wr_req       = '0;
    emit         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          type_nxt  = in_req_type;
          value_nxt = in_value;
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        unique case (type_r) inside
          dll_pkg::REQ_PUSH_FRONT, dll_pkg::REQ_PUSH_BACK: begin
            if (count_r == dll_pkg::NULL_IDX) begin
              status_nxt = dll_pkg::ST_FULL;
              state_nxt  = S_RESULT;
            end else begin
              scan_nxt  = '0;
              state_nxt = S_ALLOC;
            end
          end
          dll_pkg::REQ_REMOVE: begin
            if (!dll_pkg::idx_valid(head_r)) begin
              status_nxt = dll_pkg::ST_NOT_FOUND;
              state_nxt  = S_RESULT;
            end else begin
              rd_req.en   = 1'b1;
              rd_req.addr = head_r[dll_pkg::ADDR_W-1:0];
              cur_nxt     = head_r;
              step_nxt    = '0;
              state_nxt   = S_SEARCH;
            end
          end
          dll_pkg::REQ_LIST_FWD, dll_pkg::REQ_LIST_BWD: begin
            if (!dll_pkg::idx_valid(start_idx)) begin
              status_nxt = dll_pkg::ST_EMPTY;
              value_nxt  = '0;
              state_nxt  = S_RESULT;
            end else begin
              rd_req.en   = 1'b1;
              rd_req.addr = start_idx[dll_pkg::ADDR_W-1:0];
              step_nxt    = '0;
              state_nxt   = S_LIST;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      // Walks the free map one bit a cycle; a free entry exists since the store is not full.
      S_ALLOC: begin
        if (free_r[scan_r]) begin
          new_nxt          = dll_pkg::idx_t'(scan_r);
          free_nxt[scan_r] = 1'b0;
          count_nxt        = count_r + 1'b1;
          wr_req.val_en    = 1'b1;
          wr_req.next_en   = 1'b1;
          wr_req.prev_en   = 1'b1;
          wr_req.addr      = scan_r;
          wr_req.value     = value_r;
          wr_req.next      = dll_pkg::NULL_IDX;
          wr_req.prev      = dll_pkg::NULL_IDX;
          if (!dll_pkg::idx_valid(head_r)) begin
            head_nxt   = dll_pkg::idx_t'(scan_r);
            tail_nxt   = dll_pkg::idx_t'(scan_r);
            status_nxt = dll_pkg::ST_OK;
            state_nxt  = S_RESULT;
          end else if (type_r == dll_pkg::REQ_PUSH_FRONT) begin
            wr_req.next = head_r;
            cur_nxt     = head_r;
            head_nxt    = dll_pkg::idx_t'(scan_r);
            state_nxt   = S_LINK;
          end else begin
            wr_req.prev = tail_r;
            cur_nxt     = tail_r;
            tail_nxt    = dll_pkg::idx_t'(scan_r);
            state_nxt   = S_LINK;
          end
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end

      // Points the old end entry at the new one.
      S_LINK: begin
        wr_req.addr = cur_r[dll_pkg::ADDR_W-1:0];
        wr_req.next = new_r;
        wr_req.prev = new_r;
        if (type_r == dll_pkg::REQ_PUSH_FRONT) begin
          wr_req.prev_en = 1'b1;
        end else begin
          wr_req.next_en = 1'b1;
        end
        status_nxt = dll_pkg::ST_OK;
        state_nxt  = S_RESULT;
      end

      // One entry compared per cycle; the next read address comes straight from the read data.
      S_SEARCH: begin
        if (rd_data.value == value_r) begin
          unl_prev_nxt = rd_data.prev;
          unl_next_nxt = rd_data.next;
          state_nxt    = S_UNLINK_PREV;
        end else if (!dll_pkg::idx_valid(rd_data.next) || step_max) begin
          status_nxt = dll_pkg::ST_NOT_FOUND;
          state_nxt  = S_RESULT;
        end else begin
          rd_req.en   = 1'b1;
          rd_req.addr = rd_data.next[dll_pkg::ADDR_W-1:0];
          cur_nxt     = rd_data.next;
          step_nxt    = step_r + 1'b1;
        end
      end

      S_UNLINK_PREV: begin
        if (dll_pkg::idx_valid(unl_prev_r)) begin
          wr_req.next_en = 1'b1;
          wr_req.addr    = unl_prev_r[dll_pkg::ADDR_W-1:0];
          wr_req.next    = unl_next_r;
        end else begin
          head_nxt = unl_next_r;
        end
        state_nxt = S_UNLINK_NEXT;
      end

      S_UNLINK_NEXT: begin
        if (dll_pkg::idx_valid(unl_next_r)) begin
          wr_req.prev_en = 1'b1;
          wr_req.addr    = unl_next_r[dll_pkg::ADDR_W-1:0];
          wr_req.prev    = unl_prev_r;
        end else begin
          tail_nxt = unl_prev_r;
        end
        free_nxt[cur_r[dll_pkg::ADDR_W-1:0]] = 1'b1;
        if (count_r != '0) begin
          count_nxt = count_r - 1'b1;
        end
        status_nxt = dll_pkg::ST_OK;
        state_nxt  = S_RESULT;
      end

      // The read data holds while the result waits, since no new read is issued.
      S_LIST: begin
        emit.valid  = 1'b1;
        emit.status = dll_pkg::ST_OK;
        emit.value  = rd_data.value;
        emit.last   = list_last;
        if (emit_ok) begin
          if (list_last) begin
            state_nxt = S_IDLE;
          end else begin
            rd_req.en   = 1'b1;
            rd_req.addr = list_nx[dll_pkg::ADDR_W-1:0];
            step_nxt    = step_r + 1'b1;
          end
        end
      end

      S_RESULT: begin
        emit.valid  = 1'b1;
        emit.status = status_r;
        emit.value  = value_r;
        emit.last   = 1'b1;
        if (emit_ok) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= dll_pkg::NULL_IDX;
      tail_r  <= dll_pkg::NULL_IDX;
      count_r <= '0;
      free_r  <= '1;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      free_r  <= free_nxt;
    end
    type_r     <= type_nxt;
    value_r    <= value_nxt;
    status_r   <= status_nxt;
    scan_r     <= scan_nxt;
    step_r     <= step_nxt;
    cur_r      <= cur_nxt;
    new_r      <= new_nxt;
    unl_prev_r <= unl_prev_nxt;
    unl_next_r <= unl_next_nxt;
  end

endmodule

/* rtl/doubly_linked_list_engine.sv */
`timescale 1ns / 1ps

// Channel   Interface         Role    Transaction
// in_req    dll_req_if.sink   input   one request: req_type, value
// out_rsp   dll_rsp_if.source output  one result: status, value_out, last
//
// With the output never stalled, the time from one taken request to the next depends on the request:
// a push is set by the one-bit-a-cycle free map scan, unless the store is full; a remove by the
// match's position counted from one at the front, or by the list length if absent; a list request
// by the number of entries read through the single read port, and an empty list needs no read.
// Reset clears head, tail, count and the free map at once; the entry store is not cleared.
// A result waits in the output register while the next request is taken; a stall holds a stream.

module doubly_linked_list_engine (
  input logic       clk,
  input logic       rst_n,
  dll_req_if.sink   in_req,
  dll_rsp_if.source out_rsp
);

  dll_pkg::rsp_t    emit;
  dll_pkg::rd_req_t rd_req;
  dll_pkg::wr_req_t wr_req;
  dll_pkg::entry_t  rd_data;
  logic             emit_ok;

  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic signed [31:0] out_value_r;
  logic               out_last_r;

  assign emit_ok = !out_valid_r || out_rsp.ready;

  dll_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_req.valid),
    .in_ready    (in_req.ready),
    .in_req_type (in_req.req_type),
    .in_value    (in_req.value),
    .emit        (emit),
    .emit_ok     (emit_ok),
    .rd_req      (rd_req),
    .wr_req      (wr_req),
    .rd_data     (rd_data)
  );

  dll_store u_store (
    .clk     (clk),
    .rd_req  (rd_req),
    .wr_req  (wr_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_ok) begin
      out_valid_r <= emit.valid;
    end
    if (emit_ok && emit.valid) begin
      out_status_r <= emit.status;
      out_value_r  <= emit.value;
      out_last_r   <= emit.last;
    end
  end

  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.status    = out_status_r;
  assign out_rsp.value_out = out_value_r;
  assign out_rsp.last      = out_last_r;

endmodule

/* rtl/dll_checker.sv */
`timescale 1ns / 1ps

module dll_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_status,
  input logic signed [31:0] out_value,
  input logic               out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_value) && $stable(out_last))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while the previous one is in progress");

  a_busy_in_stream: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |-> !in_ready)
    else $error("request taken in the middle of a stream");

  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == dll_pkg::ST_EMPTY) |-> out_last && (out_value == 32'sd0))
    else $error("empty-list result is malformed");

endmodule

bind doubly_linked_list_engine dll_checker u_dll_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_req.valid),
  .in_ready   (in_req.ready),
  .out_valid  (out_rsp.valid),
  .out_ready  (out_rsp.ready),
  .out_status (out_rsp.status),
  .out_value  (out_rsp.value_out),
  .out_last   (out_rsp.last)
);
